// ===== sv/bptc_pkg.sv =====
// bptc_pkg: shared types and constants for the barometer compensation pipeline.
// Used by bptc_front, bptc_second, bptc_press and the top level.
// No dependencies.
package bptc_pkg;

  // register indexes on the configuration channel
  localparam logic [2:0] REG_C1 = 3'd0;  // pressure sensitivity
  localparam logic [2:0] REG_C2 = 3'd1;  // pressure offset
  localparam logic [2:0] REG_C3 = 3'd2;  // temp coefficient of sensitivity
  localparam logic [2:0] REG_C4 = 3'd3;  // temp coefficient of offset
  localparam logic [2:0] REG_C5 = 3'd4;  // reference temperature
  localparam logic [2:0] REG_C6 = 3'd5;  // temp coefficient of temperature

  // internal widths
  localparam int T_W    = 20;  // first-order temperature
  localparam int TC_W   = 21;  // temperature after T2 subtraction
  localparam int T2_W   = 18;  // T2 correction (non-negative)
  localparam int OFF_W  = 40;  // offset
  localparam int SENS_W = 38;  // sensitivity
  localparam int SQ_W   = 40;  // squares and second-order terms
  localparam int P_W    = 28;  // pressure before clamp

  // total register stages from input beat to output beat
  localparam int PIPE_DEPTH = 10;

  localparam logic signed [T_W-1:0]  TEMP_REF = 20'sd2000;
  localparam logic signed [T_W-1:0]  TEMP_LOW = -20'sd1500;
  localparam logic signed [TC_W-1:0] TEMP_MIN = -21'sd4000;
  localparam logic signed [TC_W-1:0] TEMP_MAX = 21'sd8500;
  localparam logic signed [P_W-1:0]  PRES_MAX = 28'sd120000;

  localparam logic [SQ_W-1:0] K_OFF_A  = 40'd5;
  localparam logic [SQ_W-1:0] K_OFF_B  = 40'd7;
  localparam logic [SQ_W-1:0] K_SENS_B = 40'd11;

  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } cal_t;

  // first-order results
  typedef struct packed {
    logic [23:0]              d1;
    logic signed [T_W-1:0]    temp;
    logic [T2_W-1:0]          t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } front_t;

  // corrected offset/sensitivity, final temperature
  typedef struct packed {
    logic [23:0]              d1;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic [14:0]              temp;
  } corr_t;

endpackage

// ===== sv/bptc_front.sv =====
// bptc_front: temperature difference, first-order temperature, offset and
// sensitivity, plus the dT^2 term. Three register stages. Uses bptc_pkg.
module bptc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  bptc_pkg::cal_t       cal,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [23:0]          raw_temperature,
  input  logic [23:0]          raw_pressure,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bptc_pkg::front_t     out_data
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // stage 1
  logic signed [24:0] dt;
  logic [23:0]        d1_s1;
  // stage 2
  logic signed [41:0] mt, mo, ms;
  logic signed [49:0] mdd;
  logic [23:0]        d1_s2;

  logic signed [24:0] dt_next;
  logic signed [41:0] mt_sh, mo_sh, ms_sh;

  assign adv3     = ~v3 | out_ready;
  assign adv2     = ~v2 | adv3;
  assign adv1     = ~v1 | adv2;
  assign in_ready = adv1;
  assign out_valid = v3;

  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'd0});

  assign mt_sh = mt >>> 23;
  assign mo_sh = mo >>> 7;
  assign ms_sh = ms >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      dt    <= dt_next;
      d1_s1 <= raw_pressure;
    end
    if (adv2) begin
      mt    <= dt * $signed({1'b0, cal.c6});
      mo    <= dt * $signed({1'b0, cal.c4});
      ms    <= dt * $signed({1'b0, cal.c3});
      mdd   <= dt * dt;
      d1_s2 <= d1_s1;
    end
    if (adv3) begin
      out_data.d1   <= d1_s2;
      out_data.temp <= bptc_pkg::T_W'(mt_sh) + bptc_pkg::TEMP_REF;
      out_data.t2   <= mdd[31 +: bptc_pkg::T2_W];  // dT^2 / 2^31, never negative
      out_data.off  <= bptc_pkg::OFF_W'(mo_sh) + $signed({8'd0, cal.c2, 16'd0});
      out_data.sens <= bptc_pkg::SENS_W'(ms_sh) + $signed({7'd0, cal.c1, 15'd0});
    end
  end

endmodule

// ===== sv/bptc_second.sv =====
// bptc_second: second-order corrections below 20 degC and -15 degC, and the
// temperature clamp. Three register stages. Uses bptc_pkg.
module bptc_second (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bptc_pkg::front_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bptc_pkg::corr_t      out_data
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  logic signed [bptc_pkg::T_W-1:0] da, db;

  // stage 1
  logic [bptc_pkg::SQ_W-1:0]          sqa, sqb;
  logic signed [bptc_pkg::TC_W-1:0]   temp_c;
  logic                               lo, vlo;
  logic signed [bptc_pkg::OFF_W-1:0]  off_s1;
  logic signed [bptc_pkg::SENS_W-1:0] sens_s1;
  logic [23:0]                        d1_s1;
  // stage 2
  logic [bptc_pkg::SQ_W-1:0]          off2, sens2;
  logic [14:0]                        temp_s2;
  logic signed [bptc_pkg::OFF_W-1:0]  off_s2;
  logic signed [bptc_pkg::SENS_W-1:0] sens_s2;
  logic [23:0]                        d1_s2;

  logic [bptc_pkg::SQ_W-1:0] off2_next, sens2_next;
  logic [14:0]               temp_clamp;

  assign adv3      = ~v3 | out_ready;
  assign adv2      = ~v2 | adv3;
  assign adv1      = ~v1 | adv2;
  assign in_ready  = adv1;
  assign out_valid = v3;

  assign da = in_data.temp - bptc_pkg::TEMP_REF;
  assign db = in_data.temp - bptc_pkg::TEMP_LOW;

  // terms are non-negative, so plain shifts are floor divisions
  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    if (lo) begin
      off2_next  = (sqa * bptc_pkg::K_OFF_A) >> 1;
      sens2_next = (sqa * bptc_pkg::K_OFF_A) >> 2;
    end
    if (vlo) begin
      off2_next  = off2_next + sqb * bptc_pkg::K_OFF_B;
      sens2_next = sens2_next + ((sqb * bptc_pkg::K_SENS_B) >> 1);
    end
  end

  always_comb begin
    priority if (temp_c < bptc_pkg::TEMP_MIN) begin
      temp_clamp = bptc_pkg::TEMP_MIN[14:0];
    end else if (temp_c > bptc_pkg::TEMP_MAX) begin
      temp_clamp = bptc_pkg::TEMP_MAX[14:0];
    end else begin
      temp_clamp = temp_c[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sqa     <= bptc_pkg::SQ_W'(da * da);
      sqb     <= bptc_pkg::SQ_W'(db * db);
      // T2 only comes off below 20 degC
      temp_c  <= {in_data.temp[bptc_pkg::T_W-1], in_data.temp}
                 - ((in_data.temp < bptc_pkg::TEMP_REF) ? {3'd0, in_data.t2}
                                                        : {bptc_pkg::TC_W{1'b0}});
      lo      <= in_data.temp < bptc_pkg::TEMP_REF;
      vlo     <= in_data.temp < bptc_pkg::TEMP_LOW;
      off_s1  <= in_data.off;
      sens_s1 <= in_data.sens;
      d1_s1   <= in_data.d1;
    end
    if (adv2) begin
      off2    <= off2_next;
      sens2   <= sens2_next;
      temp_s2 <= temp_clamp;
      off_s2  <= off_s1;
      sens_s2 <= sens_s1;
      d1_s2   <= d1_s1;
    end
    if (adv3) begin
      out_data.d1   <= d1_s2;
      out_data.off  <= off_s2 - $signed(off2);
      out_data.sens <= sens_s2 - $signed(sens2[bptc_pkg::SENS_W-1:0]);
      out_data.temp <= temp_s2;
    end
  end

endmodule

// ===== sv/bptc_press.sv =====
// bptc_press: pressure from D1 * SENS (two partial products), offset removal
// and clamp, ending in the output register. Four stages. Uses bptc_pkg.
module bptc_press (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bptc_pkg::corr_t      in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [14:0]          temperature_centideg,
  output logic [16:0]          pressure_pa
);

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  // stage 1: partial products, sens = hi * 2^19 + lo
  logic [42:0]                       pl;
  logic signed [43:0]                ph;
  logic signed [bptc_pkg::OFF_W-1:0] off_s1, off_s2;
  logic [14:0]                       temp_s1, temp_s2, temp_s3;
  // stage 2
  logic signed [41:0]                q;
  // stage 3
  logic signed [bptc_pkg::P_W-1:0]   p;

  logic signed [62:0] prod;
  logic signed [42:0] r;
  logic [16:0]        p_clamp;

  assign adv4      = ~v4 | out_ready;
  assign adv3      = ~v3 | adv4;
  assign adv2      = ~v2 | adv3;
  assign adv1      = ~v1 | adv2;
  assign in_ready  = adv1;
  assign out_valid = v4;

  assign prod = $signed({ph, 19'd0}) + $signed({20'd0, pl});
  assign r    = {q[41], q} - {{3{off_s2[bptc_pkg::OFF_W-1]}}, off_s2};

  always_comb begin
    priority if (p < 0) begin
      p_clamp = '0;
    end else if (p > bptc_pkg::PRES_MAX) begin
      p_clamp = bptc_pkg::PRES_MAX[16:0];
    end else begin
      p_clamp = p[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      pl      <= in_data.d1 * in_data.sens[18:0];
      ph      <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[37:19]);
      off_s1  <= in_data.off;
      temp_s1 <= in_data.temp;
    end
    if (adv2) begin
      q       <= prod[62:21];  // floor(D1*SENS / 2^21)
      off_s2  <= off_s1;
      temp_s2 <= temp_s1;
    end
    if (adv3) begin
      p       <= r[42:15];
      temp_s3 <= temp_s2;
    end
    if (adv4) begin
      pressure_pa          <= p_clamp;
      temperature_centideg <= temp_s3;
    end
  end

endmodule

// ===== sv/baro_pressure_temp_compensation.sv =====
// baro_pressure_temp_compensation: top level, calibration registers and the
// three pipeline sections. Uses bptc_pkg, bptc_front, bptc_second, bptc_press.
//
// Usage:
//  - Load the six calibration words through the cfg channel (index 0..5 =
//    C1..C6; other indexes are dropped). cfg_ready is always high. Write
//    only while no sample beat is in flight.
//  - Each input beat on s_axis carries one raw temperature / raw pressure
//    pair; each output beat on m_axis carries the compensated temperature
//    (0.01 degC, clamped to -40.00..85.00) and pressure (Pa, 0..120000).
//  - Exactly one output beat per input beat, in order.
//  - Stages from input beat to output valid: 3 stages front,
//    3 stages second-order, 4 stages pressure multiply/clamp.
//  - Throughput: one beat per cycle while m_axis_tready is high; every stage has
//    its own valid bit and advances when the next has room; bubbles squeeze out.
//  - When m_axis_tready is low, results back up stage by stage; s_axis_tready
//    falls only once all ten stages are full. Nothing is dropped or repeated.
//  - Reset (rst, synchronous) clears all stage valids and sets the
//    calibration words to zero.
module baro_pressure_temp_compensation (
  input  logic        clk,
  input  logic        rst,
  // calibration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
  // compensated output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [14:0] temperature_centideg, [31:15] pressure_pa
);

  bptc_pkg::cal_t   cal;
  bptc_pkg::front_t front_data;
  bptc_pkg::corr_t  corr_data;

  logic front_valid, front_ready;
  logic corr_valid, corr_ready;

  logic [14:0] temperature_centideg;
  logic [16:0] pressure_pa;

  // beats in flight, for checking only
  logic [3:0] in_flight;
  logic [3:0] in_flight_next;

  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bptc_pkg::REG_C1: cal.c1 <= cfg_data;
        bptc_pkg::REG_C2: cal.c2 <= cfg_data;
        bptc_pkg::REG_C3: cal.c3 <= cfg_data;
        bptc_pkg::REG_C4: cal.c4 <= cfg_data;
        bptc_pkg::REG_C5: cal.c5 <= cfg_data;
        bptc_pkg::REG_C6: cal.c6 <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  bptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .raw_temperature (s_axis_tdata[23:0]),
    .raw_pressure    (s_axis_tdata[47:24]),
    .out_valid       (front_valid),
    .out_ready       (front_ready),
    .out_data        (front_data)
  );

  bptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  bptc_press u_press (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (corr_valid),
    .in_ready             (corr_ready),
    .in_data              (corr_data),
    .out_valid            (m_axis_tvalid),
    .out_ready            (m_axis_tready),
    .temperature_centideg (temperature_centideg),
    .pressure_pa          (pressure_pa)
  );

  assign m_axis_tdata = {pressure_pa, temperature_centideg};

  assign in_flight_next = in_flight
                        + {3'd0, s_axis_tvalid & s_axis_tready}
                        - {3'd0, m_axis_tvalid & m_axis_tready};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight_next;
    end
  end

  // output fields stay inside their clamped ranges
  a_pres_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pressure_pa <= bptc_pkg::PRES_MAX[16:0]))
    else $error("pressure out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(temperature_centideg) >= $signed(bptc_pkg::TEMP_MIN[14:0]) &&
                       $signed(temperature_centideg) <= $signed(bptc_pkg::TEMP_MAX[14:0])))
    else $error("temperature out of range");

  // a ready sink means every stage can advance
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with ready sink");

  // occupancy never exceeds the stage count and output needs an item inside
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 4'(bptc_pkg::PIPE_DEPTH))
    else $error("more beats in flight than stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (in_flight != 4'd0))
    else $error("output beat with nothing in flight");

endmodule
